// ===== hdl/emvt_pkg.sv =====
// ----------------------------------------------------------------------------
// emvt_pkg
// Shared widths, types and helpers for the weighted mean/variance tracker.
// ----------------------------------------------------------------------------
package emvt_pkg;

    localparam int SAMPLE_BITS  = 20;
    localparam int W_BITS       = 4;
    localparam int W_MAX        = 10;
    localparam int W_RESET      = 3;
    localparam int VAL_BITS     = SAMPLE_BITS + W_MAX;   // sample scaled by 2^w
    localparam int MEAN_BITS    = 32;
    localparam int DIFF_BITS    = MEAN_BITS + 1;
    localparam int MAG_BITS     = MEAN_BITS;
    localparam int PROD_BITS    = 2 * MAG_BITS;
    localparam int ACC_BITS     = PROD_BITS + 2;
    localparam int VAR_BITS     = 52;
    localparam int VAR_OUT_BITS = 40;
    localparam int ROOT_BITS    = VAR_OUT_BITS / 2;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);
    localparam int REM_BITS     = ROOT_BITS + 2;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_BITS   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_VAR_E,
        BK_VAR_T,
        BK_VAR_UPD,
        BK_OUT,
        BK_SQRT,
        BK_LOAD
    } t_back_state;

    // one classified sample on its way to the back end
    typedef struct packed {
        logic                first;
        logic [W_BITS-1:0]   w;
        logic [VAL_BITS-1:0] val1;
    } t_q_word;

    typedef struct packed {
        logic                    start;
        logic [VAR_OUT_BITS-1:0] operand;
    } t_sqrt_req;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] root;
    } t_sqrt_res;

    function automatic logic [W_BITS-1:0] eff_weight(input logic [W_BITS-1:0] w);
        return (w > W_BITS'(W_MAX)) ? W_BITS'(W_MAX) : w;
    endfunction

endpackage

// ===== hdl/emvt_front.sv =====
// ----------------------------------------------------------------------------
// emvt_front
// Input stage: takes a sample, scales it by 2^w and tags the seed word.
// ----------------------------------------------------------------------------
module emvt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [emvt_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic [emvt_pkg::W_BITS-1:0]         i_weight,
    output logic                                o_q_valid,
    output emvt_pkg::t_q_word                   o_q_word,
    input  logic                                i_q_ready
);

    logic               r_valid;
    logic               r_seeded;
    emvt_pkg::t_q_word  r_word;
    emvt_pkg::t_q_word  n_word;
    logic [emvt_pkg::VAL_BITS-1:0] ext;
    logic               accept;

    assign o_ready   = !r_valid || i_q_ready;
    assign accept    = i_valid && o_ready;
    assign o_q_valid = r_valid;
    assign o_q_word  = r_word;

    always_comb begin
        ext = {{emvt_pkg::W_MAX{i_sample[emvt_pkg::SAMPLE_BITS-1]}}, i_sample};
        n_word.first = !r_seeded;
        n_word.w     = i_weight;
        n_word.val1  = ext << i_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_seeded <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_seeded <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== hdl/emvt_queue.sv =====
// ----------------------------------------------------------------------------
// emvt_queue
// Small FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module emvt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  emvt_pkg::t_q_word   i_push_word,
    output logic                o_pop_valid,
    input  logic                i_pop,
    output emvt_pkg::t_q_word   o_pop_word
);

    emvt_pkg::t_q_word                  r_mem [emvt_pkg::Q_DEPTH];
    logic [emvt_pkg::Q_PTR_BITS-1:0]    r_wr_ptr;
    logic [emvt_pkg::Q_PTR_BITS-1:0]    r_rd_ptr;
    logic [emvt_pkg::Q_CNT_BITS-1:0]    r_count;
    logic                               push;
    logic                               pop;

    assign o_push_ready = (r_count != emvt_pkg::Q_CNT_BITS'(emvt_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_word   = r_mem[r_rd_ptr];

    function automatic logic [emvt_pkg::Q_PTR_BITS-1:0] bump(
        input logic [emvt_pkg::Q_PTR_BITS-1:0] p
    );
        return (p == emvt_pkg::Q_PTR_BITS'(emvt_pkg::Q_DEPTH - 1)) ?
               '0 : p + emvt_pkg::Q_PTR_BITS'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + emvt_pkg::Q_CNT_BITS'(1);
            end else if (pop && !push) begin
                r_count <= r_count - emvt_pkg::Q_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

endmodule

// ===== hdl/emvt_isqrt.sv =====
// ----------------------------------------------------------------------------
// emvt_isqrt
// Floor square root, one result bit per cycle (restoring digit recurrence).
// ----------------------------------------------------------------------------
module emvt_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  emvt_pkg::t_sqrt_req i_req,
    output emvt_pkg::t_sqrt_res o_res
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [emvt_pkg::ROOT_CNT_BITS-1:0]   r_cnt;
    logic [emvt_pkg::VAR_OUT_BITS-1:0]    r_x;
    logic [emvt_pkg::REM_BITS-1:0]        r_rem;
    logic [emvt_pkg::ROOT_BITS-1:0]       r_root;

    logic [emvt_pkg::REM_BITS+1:0]        rem_sh;
    logic [emvt_pkg::REM_BITS+1:0]        trial;
    logic                                 fits;
    logic                                 last_step;

    always_comb begin
        rem_sh = {r_rem, r_x[emvt_pkg::VAR_OUT_BITS-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    assign last_step  = r_busy &&
                        (r_cnt == emvt_pkg::ROOT_CNT_BITS'(emvt_pkg::ROOT_BITS - 1));
    assign o_res.done = r_done;
    assign o_res.root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && last_step;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + emvt_pkg::ROOT_CNT_BITS'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_req.operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= r_x << 2;
            if (fits) begin
                r_rem  <= emvt_pkg::REM_BITS'(rem_sh - trial);
                r_root <= {r_root[emvt_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= emvt_pkg::REM_BITS'(rem_sh);
                r_root <= {r_root[emvt_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== hdl/emvt_back.sv =====
// ----------------------------------------------------------------------------
// emvt_back
// Recurrence sequencer: mean/variance update, result scaling, output register.
// ----------------------------------------------------------------------------
module emvt_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  emvt_pkg::t_q_word                    i_q_word,
    output logic                                 o_q_pop,
    output emvt_pkg::t_sqrt_req                  o_sqrt_req,
    input  emvt_pkg::t_sqrt_res                  i_sqrt_res,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [emvt_pkg::SAMPLE_BITS-1:0]     o_mean,
    output logic [emvt_pkg::VAR_OUT_BITS-1:0]    o_variance,
    output logic [emvt_pkg::ROOT_BITS-1:0]       o_std_dev
);

    localparam int DB = emvt_pkg::DIFF_BITS;
    localparam int MB = emvt_pkg::MEAN_BITS;
    localparam int AB = emvt_pkg::ACC_BITS;
    localparam int VB = emvt_pkg::VAR_BITS;
    localparam int OB = emvt_pkg::VAR_OUT_BITS;

    emvt_pkg::t_back_state r_state;
    emvt_pkg::t_back_state n_state;

    logic [emvt_pkg::W_BITS-1:0]        r_w;
    logic signed [MB-1:0]               r_mean;
    logic [VB-1:0]                      r_var;
    logic signed [DB-1:0]               r_d;
    logic [emvt_pkg::MAG_BITS-1:0]      r_ad;
    logic [emvt_pkg::PROD_BITS-1:0]     r_prod;
    logic [emvt_pkg::PROD_BITS-1:0]     r_e;
    logic signed [AB-1:0]               r_t;
    logic [emvt_pkg::SAMPLE_BITS-1:0]   r_mean_out;
    logic [OB-1:0]                      r_var_out;

    logic                               r_o_valid;
    logic [emvt_pkg::SAMPLE_BITS-1:0]   r_o_mean;
    logic [OB-1:0]                      r_o_var;
    logic [emvt_pkg::ROOT_BITS-1:0]     r_o_std;

    logic signed [DB-1:0]               val_ext;
    logic signed [DB-1:0]               mean_ext;
    logic signed [DB-1:0]               d;
    logic [DB-1:0]                      d_abs;
    logic [DB-1:0]                      bias_d;
    logic signed [DB-1:0]               step_d;
    logic [MB-1:0]                      bias_m;
    logic signed [MB-1:0]               mean_q;
    logic [emvt_pkg::PROD_BITS-1:0]     d2;
    logic signed [AB-1:0]               var_ext;
    logic signed [AB-1:0]               nv;
    logic [VB-1:0]                      nv_sat;
    logic [VB-1:0]                      var_sh;
    logic [OB-1:0]                      var_out;
    logic                               out_free;

    assign out_free   = !r_o_valid || i_ready;
    assign o_valid    = r_o_valid;
    assign o_mean     = r_o_mean;
    assign o_variance = r_o_var;
    assign o_std_dev  = r_o_std;

    // datapath
    always_comb begin
        val_ext  = {{(DB - emvt_pkg::VAL_BITS){i_q_word.val1[emvt_pkg::VAL_BITS-1]}},
                    i_q_word.val1};
        mean_ext = {r_mean[MB-1], r_mean};
        d        = val_ext - mean_ext;
        d_abs    = d[DB-1] ? DB'(-d) : DB'(d);

        // divide by 2^w toward zero: bias negatives before the arithmetic shift
        bias_d = r_d[DB-1] ? ((DB'(1) << r_w) - DB'(1)) : '0;
        step_d = $signed(r_d + bias_d) >>> r_w;
        bias_m = r_mean[MB-1] ? ((MB'(1) << r_w) - MB'(1)) : '0;
        mean_q = $signed(r_mean + bias_m) >>> r_w;

        d2      = r_prod >> r_w;
        var_ext = $signed({{(AB - VB){1'b0}}, r_var});
        nv      = var_ext + (r_t >>> r_w);
        if (nv[AB-1]) begin
            nv_sat = '0;
        end else if (|nv[AB-2:VB]) begin
            nv_sat = '1;
        end else begin
            nv_sat = nv[VB-1:0];
        end

        var_sh  = r_var >> r_w;
        var_out = (|var_sh[VB-1:OB]) ? '1 : var_sh[OB-1:0];
    end

    assign o_sqrt_req.start   = (r_state == emvt_pkg::BK_OUT);
    assign o_sqrt_req.operand = var_out;

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            emvt_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = i_q_word.first ? emvt_pkg::BK_OUT : emvt_pkg::BK_MUL;
                end
            end
            emvt_pkg::BK_MUL:     n_state = emvt_pkg::BK_VAR_E;
            emvt_pkg::BK_VAR_E:   n_state = emvt_pkg::BK_VAR_T;
            emvt_pkg::BK_VAR_T:   n_state = emvt_pkg::BK_VAR_UPD;
            emvt_pkg::BK_VAR_UPD: n_state = emvt_pkg::BK_OUT;
            emvt_pkg::BK_OUT:     n_state = emvt_pkg::BK_SQRT;
            emvt_pkg::BK_SQRT: begin
                if (i_sqrt_res.done) begin
                    n_state = emvt_pkg::BK_LOAD;
                end
            end
            emvt_pkg::BK_LOAD: begin
                if (out_free) begin
                    n_state = emvt_pkg::BK_IDLE;
                end
            end
            default: n_state = emvt_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= emvt_pkg::BK_IDLE;
            r_o_valid <= 1'b0;
            r_mean    <= '0;
            r_var     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == emvt_pkg::BK_LOAD && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                emvt_pkg::BK_IDLE: begin
                    if (i_q_valid && i_q_word.first) begin
                        r_mean <= MB'(val_ext);
                        r_var  <= '0;
                    end
                end
                emvt_pkg::BK_MUL: begin
                    r_mean <= r_mean + MB'(step_d);
                end
                emvt_pkg::BK_VAR_UPD: begin
                    r_var <= nv_sat;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            emvt_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    r_w  <= i_q_word.w;
                    r_d  <= d;
                    r_ad <= emvt_pkg::MAG_BITS'(d_abs);
                end
            end
            emvt_pkg::BK_MUL: begin
                r_prod <= r_ad * r_ad;
            end
            emvt_pkg::BK_VAR_E: begin
                r_e <= d2 - (d2 >> r_w);
            end
            emvt_pkg::BK_VAR_T: begin
                r_t <= $signed({2'b00, r_e}) - var_ext;
            end
            emvt_pkg::BK_OUT: begin
                r_mean_out <= mean_q[emvt_pkg::SAMPLE_BITS-1:0];
                r_var_out  <= var_out;
            end
            emvt_pkg::BK_LOAD: begin
                if (out_free) begin
                    r_o_mean <= r_mean_out;
                    r_o_var  <= r_var_out;
                    r_o_std  <= i_sqrt_res.root;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/ewm_mean_variance_tracker_core.sv =====
// The back-end sequencer works on one word at a time: pop, five recurrence steps
// (a seed word runs only the last of them), 20-step bit-serial square root and its
// done flag, then load, which waits while the output register holds a stalled word.
// The input stage and a 2-deep queue take new words while the back end works.
// Reset (i_rst_n low, synchronous) empties the pipe, clears mean and variance,
// restarts seeding and sets weight_shift to 3.
// ----------------------------------------------------------------------------
// ewm_mean_variance_tracker_core
// Exponentially weighted mean, variance and standard deviation of a sample
// stream.
// ----------------------------------------------------------------------------
module ewm_mean_variance_tracker_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [emvt_pkg::W_BITS-1:0]         i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [emvt_pkg::SAMPLE_BITS-1:0]    i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [emvt_pkg::SAMPLE_BITS-1:0]    o_mean,
    output logic [emvt_pkg::VAR_OUT_BITS-1:0]   o_variance,
    output logic [emvt_pkg::ROOT_BITS-1:0]      o_std_dev
);

    logic [emvt_pkg::W_BITS-1:0] r_weight_shift;

    logic                 f_valid;
    logic                 f_ready;
    emvt_pkg::t_q_word    f_word;
    logic                 q_valid;
    logic                 q_pop;
    emvt_pkg::t_q_word    q_word;
    emvt_pkg::t_sqrt_req  sqrt_req;
    emvt_pkg::t_sqrt_res  sqrt_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_shift <= emvt_pkg::W_BITS'(emvt_pkg::W_RESET);
        end else if (i_cfg_we) begin
            r_weight_shift <= i_cfg_wdata;
        end
    end

    emvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_weight   (emvt_pkg::eff_weight(r_weight_shift)),
        .o_q_valid  (f_valid),
        .o_q_word   (f_word),
        .i_q_ready  (f_ready)
    );

    emvt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_word  (f_word),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_word   (q_word)
    );

    emvt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_res   (sqrt_res)
    );

    emvt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_word   (q_word),
        .o_q_pop    (q_pop),
        .o_sqrt_req (sqrt_req),
        .i_sqrt_res (sqrt_res),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_mean     (o_mean),
        .o_variance (o_variance),
        .o_std_dev  (o_std_dev)
    );

endmodule

// ===== hdl/emvt_checker.sv =====
// ----------------------------------------------------------------------------
// emvt_checker
// Port-level checks for the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
module emvt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [emvt_pkg::SAMPLE_BITS-1:0]    o_mean,
    input logic [emvt_pkg::VAR_OUT_BITS-1:0]   o_variance,
    input logic [emvt_pkg::ROOT_BITS-1:0]      o_std_dev
);

    localparam int SQ_BITS   = 2 * emvt_pkg::ROOT_BITS + 2;
    localparam int OPEN_BITS = 3;   // at most five words inside the core

    logic [SQ_BITS-1:0]   sq_lo;
    logic [SQ_BITS-1:0]   sq_hi;
    logic [SQ_BITS-1:0]   var_w;
    logic [OPEN_BITS-1:0] r_open;

    assign sq_lo = SQ_BITS'(o_std_dev) * SQ_BITS'(o_std_dev);
    assign sq_hi = (SQ_BITS'(o_std_dev) + SQ_BITS'(1)) *
                   (SQ_BITS'(o_std_dev) + SQ_BITS'(1));
    assign var_w = SQ_BITS'(o_variance);

    // words taken in and not yet handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + OPEN_BITS'(i_valid && o_ready)
                             - OPEN_BITS'(o_valid && i_ready);
        end
    end

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

    // a stalled result word keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mean) &&
                                $stable(o_variance) && $stable(o_std_dev))
        else $error("result word changed while stalled");

    // std_dev is the floor square root of the variance shown with it
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (sq_lo <= var_w) && (sq_hi > var_w))
        else $error("std_dev is not floor sqrt of variance");

    // every result word belongs to a sample already taken in
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_open != '0))
        else $error("result word without an outstanding sample");

endmodule

bind ewm_mean_variance_tracker_core emvt_checker u_emvt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_mean     (o_mean),
    .o_variance (o_variance),
    .o_std_dev  (o_std_dev)
);

// ===== tb/sv/ewm_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// ewm_tracker_checker
// Watches the sample and result channels of the mean/variance tracker, runs
// its own copy of the recurrence on every accepted sample and compares each
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ewm_tracker_checker
    import emvt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [W_BITS-1:0]       i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [SAMPLE_BITS-1:0]  i_mean,
    input  logic [VAR_OUT_BITS-1:0] i_variance,
    input  logic [ROOT_BITS-1:0]    i_std_dev,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned VAR_STATE_TOP = (64'd1 << VAR_BITS) - 64'd1;
    localparam longint unsigned VAR_FIELD_TOP = (64'd1 << VAR_OUT_BITS) - 64'd1;
    localparam int              PRINT_CAP     = 100;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]  mean;
        logic [VAR_OUT_BITS-1:0] variance;
        logic [ROOT_BITS-1:0]    std_dev;
    } t_stats;

    t_stats            stats_due[$];
    logic [W_BITS-1:0] weight_reg;
    bit                primed;
    longint            mean_acc;
    longint unsigned   var_acc;

    function automatic logic [ROOT_BITS-1:0] floor_root(input logic [VAR_OUT_BITS-1:0] v);
        logic [ROOT_BITS-1:0] r;
        logic [ROOT_BITS-1:0] t;
        r = '0;
        for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            t = r | (ROOT_BITS'(1) << b);
            if (VAR_OUT_BITS'(t) * VAR_OUT_BITS'(t) <= v) r = t;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) $display("%0t tracker check: %s", $time, msg);
        o_fail_count++;
    endtask

    // one accepted sample through the recurrence; queues the word it must produce
    task automatic advance_tracker(input logic [SAMPLE_BITS-1:0] raw);
        int unsigned     w;
        longint          scale;
        longint          val;
        longint          d;
        longint          step;
        longint          nv;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned vout;
        t_stats          s;
        w = (weight_reg > W_MAX) ? W_MAX : weight_reg;
        scale = 64'sd1 <<< w;
        val = longint'($signed(raw)) * scale;
        if (!primed) begin
            mean_acc = val;
            var_acc = 0;
            primed = 1'b1;
        end else begin
            d = val - mean_acc;
            mag = (d < 0) ? -d : d;
            sq = (mag * mag) >> w;
            step = longint'(sq - (sq >> w)) - longint'(var_acc);
            nv = longint'(var_acc) + (step >>> w);
            if (nv < 0) begin
                nv = 0;
            end else if (nv > longint'(VAR_STATE_TOP)) begin
                nv = longint'(VAR_STATE_TOP);
            end
            // signed divide truncates toward zero
            mean_acc = mean_acc + d / scale;
            var_acc = nv;
        end
        vout = var_acc >> w;
        if (vout > VAR_FIELD_TOP) vout = VAR_FIELD_TOP;
        s.mean = SAMPLE_BITS'(mean_acc / scale);
        s.variance = vout[VAR_OUT_BITS-1:0];
        s.std_dev = floor_root(s.variance);
        stats_due.push_back(s);
    endtask

    task automatic compare_stats;
        t_stats want;
        if (stats_due.size() == 0) begin
            report_mismatch("result word with no sample waiting for it");
        end else begin
            want = stats_due.pop_front();
            if (i_mean !== want.mean)
                report_mismatch($sformatf("mean got %h want %h", i_mean, want.mean));
            if (i_variance !== want.variance)
                report_mismatch($sformatf("variance got %h want %h",
                                          i_variance, want.variance));
            if (i_std_dev !== want.std_dev)
                report_mismatch($sformatf("std_dev got %h want %h",
                                          i_std_dev, want.std_dev));
        end
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            weight_reg = W_BITS'(W_RESET);
            primed = 1'b0;
            mean_acc = 0;
            var_acc = 0;
            stats_due.delete();
        end else begin
            if (i_cfg_we) weight_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) advance_tracker(i_sample);
            if (i_out_valid && i_out_ready) compare_stats();
        end
        o_pending = stats_due.size();
    end

endmodule

// ===== tb/sv/tb_ewm_mean_variance_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_ewm_mean_variance_tracker_core
// Drives samples and weight settings into the tracker under changing idle
// patterns on both channels; the checker beside the block predicts and
// compares every result word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ewm_mean_variance_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import emvt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int S_TOP       = 2**(SAMPLE_BITS-1) - 1;
    localparam int S_BOTTOM    = -(2**(SAMPLE_BITS-1));
    localparam logic [SAMPLE_BITS-1:0] P_MAX = SAMPLE_BITS'(S_TOP);
    localparam logic [SAMPLE_BITS-1:0] P_MIN = SAMPLE_BITS'(S_BOTTOM);

    typedef enum {STY_MIXED, STY_HIGH, STY_LOW} t_style;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [W_BITS-1:0]       cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_BITS-1:0]  sample    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]  mean;
    logic [VAR_OUT_BITS-1:0] variance;
    logic [ROOT_BITS-1:0]    std_dev;

    int        src_idle_pct  = 0;
    int        sink_idle_pct = 0;
    int        fail_count;
    int        pending;
    int        checked;
    int        sent          = 0;
    int        cycles        = 0;
    int        walk_level    = 0;
    bit [15:0] weights_seen  = 16'h0008;

    ewm_mean_variance_tracker_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_sample    (sample),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_mean      (mean),
        .o_variance  (variance),
        .o_std_dev   (std_dev)
    );

    ewm_tracker_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample     (sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_mean       (mean),
        .i_variance   (variance),
        .i_std_dev    (std_dev),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] draw_sample(input t_style style);
        int pick;
        int v;
        int span;
        case (style)
            STY_HIGH: v = S_TOP - int'($urandom_range(0, 4095));
            STY_LOW:  v = S_BOTTOM + int'($urandom_range(0, 4095));
            default: begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    return SAMPLE_BITS'($urandom);
                end else if (pick < 18) begin
                    case ($urandom_range(3))
                        0:       v = S_TOP;
                        1:       v = S_BOTTOM;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                end else begin
                    // noisy signal around a level that jumps now and then
                    if ($urandom_range(99) < 3)
                        walk_level = S_BOTTOM + int'($urandom_range(0, 2**SAMPLE_BITS - 1));
                    span = 1 << $urandom_range(0, 16);
                    v = walk_level + int'($urandom_range(0, 2 * span)) - span;
                    if (v > S_TOP) v = S_TOP;
                    if (v < S_BOTTOM) v = S_BOTTOM;
                end
            end
        endcase
        return SAMPLE_BITS'(v);
    endfunction

    task automatic send_word(input logic [SAMPLE_BITS-1:0] s);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    // sender holds off until every predicted word has come back
    task automatic drain_results;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_weight(input logic [W_BITS-1:0] w);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        weights_seen[w] = 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [W_BITS-1:0] w, input int count,
                             input t_style style);
        write_weight(w);
        repeat (count) send_word(draw_sample(style));
    endtask

    initial begin
        src_idle_pct  = 26;
        sink_idle_pct = 46;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset weight, seed on the most negative sample
        send_word(P_MIN);
        send_word(P_MAX);
        send_word(P_MAX);
        send_word(P_MIN);
        send_word('0);
        send_word('1);
        send_word(SAMPLE_BITS'(1));
        // zero weight: mean follows sample, variance collapses
        write_weight(W_BITS'(0));
        send_word(P_MAX);
        send_word(P_MIN);
        send_word(SAMPLE_BITS'(300));
        write_weight(W_BITS'(W_MAX));
        send_word(P_MIN);
        send_word(P_MAX);
        send_word(P_MAX);
        send_word('1);
        // out-of-range weights clamp to the maximum
        write_weight(W_BITS'(15));
        send_word(P_MAX);
        send_word(P_MIN);
        send_word('0);
        write_weight(W_BITS'(11));
        send_word(SAMPLE_BITS'(1));
        send_word(P_MAX);

        run_phase(W_BITS'(2), 120, STY_MIXED);
        run_phase(W_BITS'(0), 60, STY_MIXED);
        // long climb at the widest weight, then a drop to weight 1 so the
        // stale mean blows the variance into saturation
        run_phase(W_BITS'(15), 560, STY_HIGH);

        src_idle_pct  = 46;
        sink_idle_pct = 26;
        run_phase(W_BITS'(1), 40, STY_LOW);
        run_phase(W_BITS'($urandom_range(15)), 120, STY_MIXED);
        run_phase(W_BITS'(W_MAX), 120, STY_MIXED);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(W_BITS'($urandom_range(15)), 120, STY_MIXED);
        run_phase(W_BITS'(5), 100, STY_MIXED);
        run_phase(W_BITS'(3), 60, STY_MIXED);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tracker run: %0d samples in, %0d result words checked, %0d weight settings",
                 sent, checked, $countones(weights_seen));
        $display("seeding, zero and clamped weights, mid-stream weight changes, variance "
                 , "saturation; three idle mixes on the two channels");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
